>>> sv/nfpp_pkg.sv
// shared widths and defaults for the nearest factor pair perimeter unit
`timescale 1ns / 1ps
`default_nettype none
package nfpp_pkg;
  localparam int unsigned AREA_W        = 30;
  localparam int unsigned PERIM_W       = 32;
  localparam int unsigned SHORT_W       = 15;
  localparam int unsigned LONG_W        = 30;
  localparam int unsigned AREA_BITS_DEF = 30;
endpackage
`default_nettype wire

>>> sv/nfpp_if.sv
// valid/ready channel interfaces for area words and result words
`timescale 1ns / 1ps
`default_nettype none
interface nfpp_area_if;
  logic                        valid;
  logic                        ready;
  logic [nfpp_pkg::AREA_W-1:0] area;
  modport source (output valid, output area, input ready);
  modport sink (input valid, input area, output ready);
endinterface

interface nfpp_result_if;
  logic                         valid;
  logic                         ready;
  logic [nfpp_pkg::PERIM_W-1:0] perimeter;
  logic [nfpp_pkg::SHORT_W-1:0] short_side;
  logic [nfpp_pkg::LONG_W-1:0]  long_side;
  modport source (output valid, output perimeter, output short_side, output long_side,
                  input ready);
  modport sink (input valid, input perimeter, input short_side, input long_side,
                output ready);
endinterface
`default_nettype wire

>>> sv/nearest_factor_pair_perimeter_unit.sv
// closest divisor pair and minimal perimeter by bit-serial square root and trial division
// the root takes R = (N+1)/2 steps, N = area bits used, then T trial divisions follow
// each trial is a restoring division at one quotient bit per cycle
// worst case about 2^15 trials for 30-bit areas; a zero area skips the root and the trials
// one word in flight; a new word is taken while the previous result waits at the output
// reset clears the sequencer and the output valid; no storage needs clearing
`timescale 1ns / 1ps
`default_nettype none
module nearest_factor_pair_perimeter_unit #(
  parameter int unsigned AREA_BITS = nfpp_pkg::AREA_BITS_DEF
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  nfpp_area_if.sink     req_i,
  nfpp_result_if.source rsp_o
);
  localparam int unsigned NB = (AREA_BITS < nfpp_pkg::AREA_W) ? AREA_BITS : nfpp_pkg::AREA_W;
  localparam int unsigned RB = (NB + 1) / 2;
  localparam int unsigned CW = $clog2(NB + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQRT = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          rsp_vld_q, rsp_vld_d;

  logic [NB-1:0]   n_q, n_d;
  logic [2*RB-1:0] nsh_q, nsh_d;
  logic [RB-1:0]   srem_q, srem_d;
  logic [RB-1:0]   root_q, root_d;
  logic [RB-1:0]   d_q, d_d;
  logic [NB-1:0]   dsh_q, dsh_d;
  logic [RB-1:0]   drem_q, drem_d;
  logic [NB-1:0]   q_q, q_d;

  logic [nfpp_pkg::PERIM_W-1:0] perim_q, perim_d;
  logic [nfpp_pkg::SHORT_W-1:0] short_q, short_d;
  logic [nfpp_pkg::LONG_W-1:0]  long_q, long_d;

  logic [NB-1:0] area_n;
  logic [RB+1:0] s_rem, s_trial;
  logic          s_ge;
  logic [RB:0]   v_rem;
  logic [RB-1:0] v_diff;
  logic          v_ge;
  logic [RB-1:0] v_rem_next;
  logic [NB-1:0] v_q_next;
  logic [NB:0]   side_sum;
  logic          load_rsp;

  assign area_n = req_i.area[NB-1:0];

  assign s_rem   = {srem_q, nsh_q[2*RB-1 -: 2]};
  assign s_trial = {root_q, 2'b01};
  assign s_ge    = s_rem >= s_trial;

  assign v_rem      = {drem_q, dsh_q[NB-1]};
  assign v_diff     = RB'(v_rem - {1'b0, d_q});
  assign v_ge       = v_rem >= {1'b0, d_q};
  assign v_rem_next = v_ge ? v_diff : v_rem[RB-1:0];
  assign v_q_next   = {q_q[NB-2:0], v_ge};

  assign side_sum = {{(NB + 1 - RB){1'b0}}, d_q} + {1'b0, q_q};
  assign load_rsp = (state_q == ST_FIN) && (!rsp_vld_q || rsp_o.ready);

  assign req_i.ready      = state_q == ST_IDLE;
  assign rsp_o.valid      = rsp_vld_q;
  assign rsp_o.perimeter  = perim_q;
  assign rsp_o.short_side = short_q;
  assign rsp_o.long_side  = long_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rsp_vld_d = rsp_vld_q;
    n_d       = n_q;
    nsh_d     = nsh_q;
    srem_d    = srem_q;
    root_d    = root_q;
    d_d       = d_q;
    dsh_d     = dsh_q;
    drem_d    = drem_q;
    q_d       = q_q;
    perim_d   = perim_q;
    short_d   = short_q;
    long_d    = long_q;

    if (rsp_o.ready) begin
      rsp_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          n_d    = area_n;
          nsh_d  = (2*RB)'(area_n);
          srem_d = '0;
          root_d = '0;
          d_d    = '0;
          q_d    = '0;
          cnt_d  = CW'(RB);
          state_d = (area_n == '0) ? ST_FIN : ST_SQRT;
        end
      end
      ST_SQRT: begin
        nsh_d = {nsh_q[2*RB-3:0], 2'b00};
        if (s_ge) begin
          srem_d = RB'(s_rem - s_trial);
          root_d = {root_q[RB-2:0], 1'b1};
        end else begin
          srem_d = s_rem[RB-1:0];
          root_d = {root_q[RB-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          d_d     = root_d;
          dsh_d   = n_q;
          drem_d  = '0;
          q_d     = '0;
          cnt_d   = CW'(NB);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        dsh_d  = {dsh_q[NB-2:0], 1'b0};
        drem_d = v_rem_next;
        q_d    = v_q_next;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          if (v_rem_next == '0) begin
            state_d = ST_FIN;
          end else begin
            d_d    = d_q - 1'b1;
            dsh_d  = n_q;
            drem_d = '0;
            q_d    = '0;
            cnt_d  = CW'(NB);
          end
        end
      end
      ST_FIN: begin
        if (load_rsp) begin
          perim_d   = nfpp_pkg::PERIM_W'({side_sum, 1'b0});
          short_d   = nfpp_pkg::SHORT_W'(d_q);
          long_d    = nfpp_pkg::LONG_W'(q_q);
          rsp_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    nsh_q   <= nsh_d;
    srem_q  <= srem_d;
    root_q  <= root_d;
    d_q     <= d_d;
    dsh_q   <= dsh_d;
    drem_q  <= drem_d;
    q_q     <= q_d;
    perim_q <= perim_d;
    short_q <= short_d;
    long_q  <= long_d;
  end

  // trial divisor never reaches zero while dividing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> d_q != '0)
    else $error("trial divisor is zero");

  // step counter is live in the serial states
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT || state_q == ST_DIV) |-> cnt_q != '0)
    else $error("step counter ran out");

  // the found pair has long side not below short side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN |-> q_q >= {{(NB - RB){1'b0}}, d_q})
    else $error("long side below short side");

  // a result word only appears out of the finish state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_vld_q) |-> $past(state_q) == ST_FIN)
    else $error("result valid without finish");

  // no new word is taken while still working
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT || state_q == ST_DIV) |-> !req_i.ready)
    else $error("input ready while busy");
endmodule
`default_nettype wire
